@@ design/lcg_pkg.sv @@
// Shared types and constants of the linear congruential random source.
// Used by the controller, the datapath and the top level; no dependencies.
package lcg_pkg;

  localparam int unsigned StateW   = 32;
  localparam int unsigned FracBits = 23;
  localparam int unsigned RawBits  = 15;
  localparam int unsigned RawLsb   = 16;
  localparam int unsigned MantLsb  = StateW - FracBits;
  localparam int unsigned DivCntW  = $clog2(RawBits);
  localparam int unsigned ProdW    = StateW + FracBits;

  localparam logic [StateW-1:0] LcgMul = 32'h0003_43FD;
  localparam logic [StateW-1:0] LcgAdd = 32'h0026_9EC3;

  typedef enum logic [2:0] {
    KIND_RAW    = 3'd0,
    KIND_RANGED = 3'd1,
    KIND_UNIT   = 3'd2,
    KIND_SIGNED = 3'd3,
    KIND_SCALED = 3'd4,
    KIND_SEED   = 3'd5
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic               capture;
    logic               advance;
    logic               div_step;
    logic [DivCntW-1:0] div_idx;
    logic               mul;
    logic               load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  span_zero;
  } dp_stat_t;

endpackage

@@ design/lcg_ifs.sv @@
// Request and response channel interfaces of the random source.
// Depends on lcg_pkg for field widths.
interface lcg_req_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        kind;
  logic signed [lcg_pkg::StateW-1:0] range_low;
  logic signed [lcg_pkg::StateW-1:0] range_high;
  logic signed [lcg_pkg::StateW-1:0] scale_low;
  logic signed [lcg_pkg::StateW-1:0] scale_high;
  logic [lcg_pkg::StateW-1:0]        new_seed;

  modport source (output valid, kind, range_low, range_high, scale_low, scale_high,
                  new_seed, input ready);
  modport sink (input valid, kind, range_low, range_high, scale_low, scale_high,
                new_seed, output ready);
endinterface

interface lcg_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [lcg_pkg::StateW-1:0] value;
  logic                              span_error;

  modport source (output valid, value, span_error, input ready);
  modport sink (input valid, value, span_error, output ready);
endinterface

@@ design/lcg_ctrl.sv @@
// Sequencing controller of the random source: handshakes, divider step count
// and output register valid. Depends on lcg_pkg.
module lcg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  lcg_pkg::dp_stat_t stat_i,
  output lcg_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_DIV,
    ST_MUL,
    ST_WRITE
  } state_e;

  state_e                      state_q;
  logic [lcg_pkg::DivCntW-1:0] cnt_q;
  logic                        out_valid_q;
  logic                        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.advance  = (state_q == ST_ADV);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.div_idx  = cnt_q;
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.load_out = (state_q == ST_WRITE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (stat_i.kind == lcg_pkg::KIND_RANGED && !stat_i.span_zero) begin
            state_q <= ST_DIV;
            cnt_q   <= lcg_pkg::DivCntW'(lcg_pkg::RawBits - 1);
          end else if (stat_i.kind == lcg_pkg::KIND_SCALED) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_WRITE;
          end
        end
        ST_DIV: begin
          // one remainder step per cycle, most significant raw bit first
          if (cnt_q == '0) begin
            state_q <= ST_WRITE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_then_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ADV))
    else $error("accepted transaction did not start advance");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_WRITE))
    else $error("divider did not finish after last step");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while occupied");

  a_valid_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WRITE))
    else $error("result raised outside write state");
`endif

endmodule

@@ design/lcg_dpath.sv @@
// Datapath of the random source: generator state, bit-serial remainder unit,
// scale multiplier and output register. Depends on lcg_pkg.
module lcg_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lcg_pkg::dp_cmd_t                  cmd_i,
  output lcg_pkg::dp_stat_t                 stat_o,
  input  logic [2:0]                        kind_i,
  input  logic signed [lcg_pkg::StateW-1:0] range_low_i,
  input  logic signed [lcg_pkg::StateW-1:0] range_high_i,
  input  logic signed [lcg_pkg::StateW-1:0] scale_low_i,
  input  logic signed [lcg_pkg::StateW-1:0] scale_high_i,
  input  logic [lcg_pkg::StateW-1:0]        new_seed_i,
  output logic signed [lcg_pkg::StateW-1:0] value_o,
  output logic                              span_error_o
);

  lcg_pkg::kind_e              kind_q;
  logic [lcg_pkg::StateW-1:0]  range_low_q, range_high_q;
  logic [lcg_pkg::StateW-1:0]  scale_low_q, scale_high_q, seed_q;
  logic [lcg_pkg::StateW-1:0]  lcg_q;
  logic [lcg_pkg::RawBits-1:0] rem_q;
  logic [lcg_pkg::StateW-1:0]  mag_q;
  logic                        neg_q;
  logic [lcg_pkg::ProdW-1:0]   prod_q;
  logic [lcg_pkg::StateW-1:0]  value_q, value_d;
  logic                        err_q, err_d;

  logic [lcg_pkg::StateW-1:0]   span, abs_span;
  logic [lcg_pkg::RawBits:0]    trial;
  logic [lcg_pkg::StateW:0]     diff, mag;
  logic                         neg;
  logic [lcg_pkg::FracBits-1:0] mant;
  logic [lcg_pkg::ProdW:0]      prod_sum;
  logic [lcg_pkg::StateW-1:0]   q;
  logic [lcg_pkg::StateW-1:0]   next_state;

  assign span     = range_high_q + 32'd1 - range_low_q;
  assign abs_span = span[lcg_pkg::StateW-1] ? (~span + 32'd1) : span;
  assign trial    = {rem_q, lcg_q[lcg_pkg::RawLsb + cmd_i.div_idx]};

  // exact 33-bit difference of the scale bounds
  assign diff = {scale_high_q[lcg_pkg::StateW-1], scale_high_q}
              - {scale_low_q[lcg_pkg::StateW-1], scale_low_q};
  assign neg  = diff[lcg_pkg::StateW];
  assign mag  = neg ? (~diff + 33'd1) : diff;
  assign mant = lcg_q[lcg_pkg::StateW-1:lcg_pkg::MantLsb];

  // round the magnitude up for a negative span so the result floors
  assign prod_sum = {1'b0, prod_q}
                  + (neg_q ? (lcg_pkg::ProdW+1)'((1 << lcg_pkg::FracBits) - 1)
                           : '0);
  assign q = prod_sum[lcg_pkg::ProdW-1:lcg_pkg::FracBits];

  assign next_state = lcg_pkg::StateW'(lcg_q * lcg_pkg::LcgMul) + lcg_pkg::LcgAdd;

  assign stat_o.kind      = kind_q;
  assign stat_o.span_zero = (span == '0);

  always_comb begin
    value_d = '0;
    err_d   = 1'b0;
    case (kind_q)
      lcg_pkg::KIND_RAW: begin
        value_d = {17'd0, lcg_q[lcg_pkg::RawLsb +: lcg_pkg::RawBits]};
      end
      lcg_pkg::KIND_RANGED: begin
        if (span == '0) begin
          value_d = range_low_q;
          err_d   = 1'b1;
        end else begin
          value_d = {17'd0, rem_q} + range_low_q;
        end
      end
      lcg_pkg::KIND_UNIT: begin
        value_d = {9'd0, mant};
      end
      lcg_pkg::KIND_SIGNED: begin
        value_d = {8'd0, mant, 1'b0} - 32'h0080_0000;
      end
      lcg_pkg::KIND_SCALED: begin
        value_d = neg_q ? (scale_low_q - q) : (scale_low_q + q);
      end
      default: begin
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= '0;
    end else if (cmd_i.advance) begin
      if (kind_q == lcg_pkg::KIND_SEED) begin
        lcg_q <= seed_q;
      end else if (kind_q inside {lcg_pkg::KIND_RAW, lcg_pkg::KIND_RANGED,
                                  lcg_pkg::KIND_UNIT, lcg_pkg::KIND_SIGNED,
                                  lcg_pkg::KIND_SCALED}) begin
        lcg_q <= next_state;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q       <= lcg_pkg::kind_e'(kind_i);
      range_low_q  <= range_low_i;
      range_high_q <= range_high_i;
      scale_low_q  <= scale_low_i;
      scale_high_q <= scale_high_i;
      seed_q       <= new_seed_i;
    end
    // hold the span magnitude so the multiply cycle starts from a register
    if (cmd_i.advance) begin
      mag_q <= mag[lcg_pkg::StateW-1:0];
      neg_q <= neg;
    end
    if (cmd_i.advance) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      // restoring remainder step
      if ({16'd0, trial} >= abs_span) begin
        rem_q <= lcg_pkg::RawBits'(trial - abs_span[lcg_pkg::RawBits:0]);
      end else begin
        rem_q <= trial[lcg_pkg::RawBits-1:0];
      end
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * mant;
    end
    if (cmd_i.load_out) begin
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  assign value_o      = value_q;
  assign span_error_o = err_q;

endmodule

@@ design/lcg_random_generator_core.sv @@
// Linear congruential random source, top level; depends on lcg_pkg, lcg_ifs, lcg_ctrl, lcg_dpath.
// An accepted transaction goes to the advance state, then to the divider steps for a non-zero
// ranged span or the multiply state for scaled, then to write; raw, fraction, seed, unused kinds
// and a zero-span ranged draw go from advance straight to write. One transaction at a time: the
// next is taken the cycle after the result is written, and the write waits while the output stalls.
// Reset clears the generator state to zero and the output valid; no clearing pass.
module lcg_random_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcg_req_if.sink   req_i,
  lcg_rsp_if.source rsp_o
);

  lcg_pkg::dp_cmd_t  cmd;
  lcg_pkg::dp_stat_t stat;

  lcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcg_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (req_i.kind),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .scale_low_i  (req_i.scale_low),
    .scale_high_i (req_i.scale_high),
    .new_seed_i   (req_i.new_seed),
    .value_o      (rsp_o.value),
    .span_error_o (rsp_o.span_error)
  );

endmodule

@@ test/lcg_random_generator_core_tb.sv @@
// Self-checking testbench of lcg_random_generator_core: directed and random requests
// against an internal prediction of the generator state. Depends on lcg_pkg, the
// lcg_req_if and lcg_rsp_if interfaces and the core itself.
module lcg_random_generator_core_tb;

  localparam int CyclePeriod = 4;
  localparam int ResetCycles = 12;
  localparam int RandomItems = 1800;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 40;
  localparam int ReportMax   = 10;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam logic signed [lcg_pkg::StateW-1:0] IntMin = 32'sh8000_0000;
  localparam logic signed [lcg_pkg::StateW-1:0] IntMax = 32'sh7FFF_FFFF;
  localparam logic signed [lcg_pkg::StateW-1:0] QOne   = 32'sh0001_0000;

  typedef struct {
    logic [2:0]                        kind;
    logic signed [lcg_pkg::StateW-1:0] range_low;
    logic signed [lcg_pkg::StateW-1:0] range_high;
    logic signed [lcg_pkg::StateW-1:0] scale_low;
    logic signed [lcg_pkg::StateW-1:0] scale_high;
    logic [lcg_pkg::StateW-1:0]        new_seed;
  } req_item_t;

  typedef struct {
    logic [lcg_pkg::StateW-1:0] value;
    logic                       span_error;
  } draw_t;

  logic clk_i;
  logic rst_ni;

  lcg_req_if req_if ();
  lcg_rsp_if rsp_if ();

  lcg_random_generator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_item_t                  pending_req_q[$];
  draw_t                      expected_draw_q[$];
  logic [lcg_pkg::StateW-1:0] gen_state = '0;
  int                         item_total  = 0;
  int                         checked_cnt = 0;
  int                         fail_cnt    = 0;
  int                         cycle_cnt   = 0;

  // Advance the generator like the block does and work out the draw it returns.
  function automatic draw_t next_draw(req_item_t it);
    draw_t                        d;
    logic [lcg_pkg::StateW-1:0]   raw;
    logic [lcg_pkg::StateW-1:0]   span;
    logic [lcg_pkg::StateW-1:0]   span_mag;
    logic [lcg_pkg::FracBits-1:0] mant;
    longint                       lo;
    longint                       hi;
    longint                       diff;
    longint                       mag;
    longint                       prod;
    longint                       off;
    d.value      = '0;
    d.span_error = 1'b0;
    if (it.kind == lcg_pkg::KIND_SEED) begin
      gen_state = it.new_seed;
      return d;
    end
    if (it.kind == KIND_SPARE_LO || it.kind == KIND_SPARE_HI)
      return d;
    gen_state = gen_state * lcg_pkg::LcgMul + lcg_pkg::LcgAdd;
    raw  = lcg_pkg::StateW'(gen_state[lcg_pkg::RawLsb +: lcg_pkg::RawBits]);
    mant = gen_state[lcg_pkg::MantLsb +: lcg_pkg::FracBits];
    case (it.kind)
      lcg_pkg::KIND_RAW: begin
        d.value = raw;
      end
      lcg_pkg::KIND_RANGED: begin
        span = it.range_high + 32'd1 - it.range_low;
        if (span == '0) begin
          d.span_error = 1'b1;
          d.value      = it.range_low;
        end else begin
          // the most negative span negates to itself, which is the 2^31 magnitude
          span_mag = span[lcg_pkg::StateW-1] ? -span : span;
          d.value  = raw % span_mag + it.range_low;
        end
      end
      lcg_pkg::KIND_UNIT: begin
        d.value = lcg_pkg::StateW'(mant);
      end
      lcg_pkg::KIND_SIGNED: begin
        d.value = (lcg_pkg::StateW'(mant) << 1)
                - (lcg_pkg::StateW'(1) << lcg_pkg::FracBits);
      end
      lcg_pkg::KIND_SCALED: begin
        lo   = longint'(it.scale_low);
        hi   = longint'(it.scale_high);
        diff = hi - lo;
        mag  = (diff < 0) ? -diff : diff;
        prod = mag * longint'({1'b0, mant});
        // floor of a negative offset means rounding the magnitude up
        if (diff < 0)
          off = -((prod + ((longint'(1) << lcg_pkg::FracBits) - 1)) >> lcg_pkg::FracBits);
        else
          off = prod >> lcg_pkg::FracBits;
        d.value = lcg_pkg::StateW'(lo + off);
      end
      default: begin
        d.value = '0;
      end
    endcase
    return d;
  endfunction

  function automatic req_item_t mk_req(logic [2:0] kind,
                                       logic signed [lcg_pkg::StateW-1:0] a,
                                       logic signed [lcg_pkg::StateW-1:0] b,
                                       logic [lcg_pkg::StateW-1:0] seed);
    req_item_t it;
    it.kind       = kind;
    it.range_low  = a;
    it.range_high = b;
    it.scale_low  = a;
    it.scale_high = b;
    it.new_seed   = seed;
    return it;
  endfunction

  // Mostly well-formed draws of every kind, with bounds shaped towards the corners.
  function automatic req_item_t rand_req();
    req_item_t it;
    int        pick;
    it.range_low  = $urandom;
    it.range_high = $urandom;
    it.scale_low  = $urandom;
    it.scale_high = $urandom;
    it.new_seed   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12)      it.kind = lcg_pkg::KIND_RAW;
    else if (pick < 40) it.kind = lcg_pkg::KIND_RANGED;
    else if (pick < 52) it.kind = lcg_pkg::KIND_UNIT;
    else if (pick < 64) it.kind = lcg_pkg::KIND_SIGNED;
    else if (pick < 88) it.kind = lcg_pkg::KIND_SCALED;
    else if (pick < 96) it.kind = lcg_pkg::KIND_SEED;
    else if (pick < 98) it.kind = KIND_SPARE_LO;
    else                it.kind = KIND_SPARE_HI;
    if (it.kind == lcg_pkg::KIND_RANGED) begin
      case ($urandom_range(0, 5))
        0: it.range_high = it.range_low + $urandom_range(0, 64) - 1;
        1: it.range_high = it.range_low + $urandom_range(30000, 40000);
        2: it.range_high = it.range_low - 1;
        3: it.range_high = it.range_low - $urandom_range(2, 5000);
        4: it.range_high = it.range_low + IntMax;
        default: ;
      endcase
    end else if (it.kind == lcg_pkg::KIND_SCALED) begin
      case ($urandom_range(0, 3))
        0: begin
          it.scale_low  = {{12{it.scale_low[19]}}, it.scale_low[19:0]};
          it.scale_high = {{12{it.scale_high[19]}}, it.scale_high[19:0]};
        end
        1: it.scale_high = it.scale_low;
        default: ;
      endcase
    end
    return it;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #(CyclePeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("lcg_random_generator_core: mismatch");
      $finish;
    end
  end

  // Request driver: bursts of back-to-back transactions separated by random gaps.
  req_item_t cur_req;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_draw_q.push_back(next_draw(cur_req));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          req_if.valid <= 1'b0;
          gap_left--;
        end else if (pending_req_q.size() != 0) begin
          cur_req = pending_req_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.kind       <= cur_req.kind;
          req_if.range_low  <= cur_req.range_low;
          req_if.range_high <= cur_req.range_high;
          req_if.scale_low  <= cur_req.scale_low;
          req_if.scale_high <= cur_req.scale_high;
          req_if.new_seed   <= cur_req.new_seed;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6:    gap_left = $urandom_range(1, 3);
              7, 8:       gap_left = $urandom_range(4, 20);
              default:    gap_left = $urandom_range(1, 17);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response stall: a rotating ready mask, replaced now and then.
  logic [15:0] stall_pat;
  int          pat_age = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_pat = 16'hFFFF;
      pat_age   = 0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pat = 16'hFFFF;
          2:       stall_pat = 16'($urandom) | 16'h0001;
          3:       stall_pat = 16'h0101;
          default: stall_pat = 16'h8000;
        endcase
        pat_age = $urandom_range(32, 256);
      end
      pat_age--;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      rsp_if.ready <= stall_pat[0];
    end
  end

  // Result monitor: compare each transaction with the oldest predicted draw.
  draw_t want;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_draw_q.size() == 0) begin
        if (fail_cnt < ReportMax)
          $display("unexpected result: value %h span_error %b", rsp_if.value,
                   rsp_if.span_error);
        fail_cnt++;
      end else begin
        want = expected_draw_q.pop_front();
        checked_cnt++;
        if (rsp_if.value !== want.value || rsp_if.span_error !== want.span_error) begin
          if (fail_cnt < ReportMax)
            $display("result %0d: expected value %h span_error %b, got value %h span_error %b",
                     checked_cnt, want.value, want.span_error, rsp_if.value,
                     rsp_if.span_error);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = lcg_pkg::KIND_RAW;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    req_if.scale_low  = '0;
    req_if.scale_high = '0;
    req_if.new_seed   = '0;
    rsp_if.ready      = 1'b0;

    // corners first: seed extremes, zero and most negative spans, reversed bounds
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RAW, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SEED, 0, 0, 32'hFFFF_FFFF));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RAW, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_UNIT, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SIGNED, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SEED, 0, 0, 32'h0000_0000));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SIGNED, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, 0, 0, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, IntMin, IntMax, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, 0, -1, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, 0, IntMax, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, IntMin, -1, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, 10, -10, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, -5, 5, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, 0, 32767, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RANGED, IntMax, IntMax, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SCALED, IntMin, IntMax, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SCALED, IntMax, IntMin, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SCALED, QOne, QOne, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SCALED, 0, QOne, 0));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SCALED, QOne, -QOne, 0));
    pending_req_q.push_back(mk_req(KIND_SPARE_LO, IntMin, IntMax, 32'hFFFF_FFFF));
    pending_req_q.push_back(mk_req(KIND_SPARE_HI, IntMax, IntMin, 32'hFFFF_FFFF));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_SEED, 0, 0, 32'h8000_0000));
    pending_req_q.push_back(mk_req(lcg_pkg::KIND_RAW, 0, 0, 0));
    for (int i = 0; i < RandomItems; i++)
      pending_req_q.push_back(rand_req());
    item_total = pending_req_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni = 1'b1;

    while (checked_cnt < item_total) @(posedge clk_i);
    // hold a little longer to catch any stray result
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("lcg_random_generator_core: match");
    end else begin
      $display("lcg_random_generator_core: mismatch");
    end
    $finish;
  end

endmodule
